/* src/rci_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rci_pkg: shared types and widths for the ray/circle intersection block
// Request and response structs, the side data carried down the root chain,
// and the fixed-point widths that follow from the coordinate width.
// ---------------------------------------------------------------------------
package rci_pkg;

  localparam int COORD_W = 32;             // Q16.16 coordinates
  localparam int DIR_W   = 16;             // Q2.14 direction and normal
  localparam int ID_W    = 16;

  // offset and dot product
  localparam int V_W     = COORD_W + 1;            // centre - origin
  localparam int PD_W    = V_W + DIR_W;            // one term of v.d, Q.30
  localparam int DOT_W   = COORD_W + 18;           // v.d sum, Q.30
  localparam int RND_DOT = 6;
  localparam int A_W     = DOT_W - RND_DOT;        // projection, Q.24

  // squares and discriminant
  localparam int VSQ_W   = 2 * V_W;                // |v|^2, Q.32
  localparam int RSQ_W   = 2 * COORD_W;            // r^2, Q.32
  localparam int ASQ_W   = 2 * A_W;                // a^2, Q.48
  localparam int DIFF_W  = VSQ_W + 1;              // r^2 - |v|^2, signed
  localparam int DISC_W  = ASQ_W + 1;              // discriminant, signed Q.48
  localparam int RAD_W   = 2 * COORD_W + 24;       // radicand, even width
  localparam int ROOT_W  = RAD_W / 2;              // root, Q.24
  localparam int REM_W   = ROOT_W + 2;

  // distance and point
  localparam int T24_W   = A_W + 2;
  localparam int RND_T   = 8;
  localparam int T16_W   = T24_W - RND_T;          // distance, Q.16
  localparam int MT_W    = T16_W + DIR_W;          // d * t, Q.30
  localparam int RND_P   = 14;
  localparam int PR_W    = MT_W - RND_P;           // rounded step, Q.16
  localparam int PS_W    = PR_W + 1;               // origin + step

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [DIR_W-1:0]   DIR_MAX   = {1'b0, {(DIR_W-1){1'b1}}};
  localparam logic [DIR_W-1:0]   DIR_MIN   = {1'b1, {(DIR_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] ray_origin_x;
    logic signed [COORD_W-1:0] ray_origin_y;
    logic signed [DIR_W-1:0]   ray_dir_x;
    logic signed [DIR_W-1:0]   ray_dir_y;
    logic signed [COORD_W-1:0] circle_center_x;
    logic signed [COORD_W-1:0] circle_center_y;
    logic        [COORD_W-2:0] circle_radius;
    logic        [ID_W-1:0]    body_id;
  } rci_req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] hit_point_x;
    logic signed [COORD_W-1:0] hit_point_y;
    logic signed [DIR_W-1:0]   normal_x;
    logic signed [DIR_W-1:0]   normal_y;
    logic signed [COORD_W-1:0] distance;
    logic        [ID_W-1:0]    hit_body;
  } rci_rsp_t;

  // request data that rides along unchanged
  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [DIR_W-1:0]   dx;
    logic signed [DIR_W-1:0]   dy;
    logic        [ID_W-1:0]    id;
  } rci_pass_t;

  // side data handed down the root chain
  typedef struct packed {
    logic                  hit;
    logic                  in_circle;
    logic signed [A_W-1:0] a;
    rci_pass_t             pass;
  } rci_side_t;

endpackage
`default_nettype wire

/* src/rci_square.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rci_square: two-stage squarer
// Splits the magnitude into halves, registers the three partial products,
// then registers their aligned sum. Result is the unsigned square.
// ---------------------------------------------------------------------------
module rci_square #(
  parameter int N = 32
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [N-1:0] x,
  output logic         [2*N-1:0]   sq
);

  localparam int L = (N + 1) / 2;
  localparam int H = N - L;

  logic [N-1:0]     mag;
  logic [H-1:0]     hi;
  logic [L-1:0]     lo;
  logic [2*H-1:0]   hh;
  logic [H+L-1:0]   hl;
  logic [2*L-1:0]   ll;

  assign mag = x[N-1] ? (~x + 1'b1) : x;
  assign hi  = mag[N-1:L];
  assign lo  = mag[L-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      hh <= hi * hi;
      hl <= hi * lo;
      ll <= lo * lo;
      sq <= {hh, {(2*L){1'b0}}}
          + (2*N)'({hl, {(L+1){1'b0}}})
          + (2*N)'(ll);
    end
  end

endmodule
`default_nettype wire

/* src/rci_root_cell.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rci_root_cell: one digit of the square root chain
// Brings down two radicand bits, tries root*4+1 against the partial
// remainder and settles one root bit. Side data moves along with it.
// ---------------------------------------------------------------------------
module rci_root_cell
  import rci_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              src_valid,
  input  wire logic [RAD_W-1:0]  src_rad,
  input  wire logic [REM_W-1:0]  src_rem,
  input  wire logic [ROOT_W-1:0] src_root,
  input  wire rci_side_t         src_side,
  output logic                   valid,
  output logic [RAD_W-1:0]       rad,
  output logic [REM_W-1:0]       rem,
  output logic [ROOT_W-1:0]      root,
  output rci_side_t              side
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  assign rem_sh = {src_rem[REM_W-3:0], src_rad[RAD_W-1 -: 2]};
  assign trial  = {src_root, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad  <= {src_rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {src_root[ROOT_W-2:0], fits};
      side <= src_side;
    end
  end

endmodule
`default_nettype wire

/* src/rci_out_buf.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rci_out_buf: response register with skid entry
// Holds the response on the port; a second entry catches the one result
// still in flight when the receiver stalls. Full freezes the pipeline.
// ---------------------------------------------------------------------------
module rci_out_buf
  import rci_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     src_valid,
  input  wire rci_rsp_t src,
  output logic          valid,
  output rci_rsp_t      data,
  input  wire logic     stall,
  output logic          full
);

  rci_rsp_t skid;
  logic     pop;
  logic     push;

  assign pop  = valid && !stall;
  assign push = src_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      full  <= 1'b0;
    end else if (full) begin
      if (pop) begin
        full <= 1'b0;
      end
    end else if (push) begin
      valid <= 1'b1;
      if (valid && !pop) begin
        full <= 1'b1;
      end
    end else if (pop) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (full) begin
      if (pop) begin
        data <= skid;
      end
    end else if (push) begin
      if (valid && !pop) begin
        skid <= src;
      end else begin
        data <= src;
      end
    end
  end

endmodule
`default_nettype wire

/* src/ray_circle_intersect_top.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ray_circle_intersect_top: 2D ray against circle intersection
// Pipelined test of one ray/circle request per cycle when not stalled:
// projection, squared distances, discriminant, a chain of square root
// cells, then distance, hit point, normal and saturation.
// ---------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  req     | req_valid / req_stall  | rci_req_t: ray, circle, body id
//  rsp     | rsp_valid / rsp_stall  | rci_rsp_t: hit, point, normal, distance
//
//  One request enters per cycle while req_stall is low; one response leaves per request, in order.
//  The square root chain has ROOT_W cells, one root bit per cell.
//  Reset clears only the valid bits and the response buffer flags; data registers are not reset.
//  When the response is stalled, one more result lands in the skid entry;
//  req_stall then rises and the whole pipeline holds until it drains.
//
module ray_circle_intersect_top
  import rci_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire rci_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output rci_rsp_t      rsp
);

  // saturate an extended Q16.16 value to the coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic [PS_W-1:0] v);
    logic [PS_W-COORD_W:0] hdr;
    hdr = v[PS_W-1:COORD_W-1];
    if (hdr == '0 || hdr == '1) begin
      return v[COORD_W-1:0];
    end else if (v[PS_W-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

  // negate a direction component; the most negative code clips
  function automatic logic [DIR_W-1:0] neg_dir(input logic [DIR_W-1:0] d);
    if (d == DIR_MIN) begin
      return DIR_MAX;
    end else begin
      return ~d + 1'b1;
    end
  endfunction

  logic en;     // global advance: low only while the skid entry is full
  logic full;

  assign en        = !full;
  assign req_stall = full;

  // ---- stage 1: offset v = centre - origin -------------------------------
  logic                     s1_valid;
  logic signed [V_W-1:0]    s1_vx, s1_vy;
  logic        [COORD_W-2:0] s1_r;
  rci_pass_t                s1_pass;

  // ---- stage 2: dot product terms ----------------------------------------
  logic                     s2_valid;
  logic signed [PD_W-1:0]   s2_pdx, s2_pdy;
  rci_pass_t                s2_pass;

  // ---- stage 3: projection a, rounded to Q.24 ----------------------------
  logic                     s3_valid;
  logic signed [A_W-1:0]    s3_a;
  rci_pass_t                s3_pass;
  logic signed [DOT_W-1:0]  dot;

  // ---- stage 4: |v|^2 and r^2 ---------------------------------------------
  logic                     s4_valid;
  logic        [VSQ_W-1:0]  s4_v2;
  logic        [RSQ_W-1:0]  s4_r2;
  logic signed [A_W-1:0]    s4_a;
  rci_pass_t                s4_pass;

  // ---- stage 5: r^2 - |v|^2, inside flag ----------------------------------
  logic                     s5_valid;
  logic        [DIFF_W-1:0] s5_diff;
  logic                     s5_inside;
  logic signed [A_W-1:0]    s5_a;
  rci_pass_t                s5_pass;

  // ---- stage 6: discriminant, head of the root chain ----------------------
  logic                     s6_valid;
  logic        [RAD_W-1:0]  s6_rad;
  rci_side_t                s6_side;
  logic        [DISC_W-1:0] disc;

  // squarer outputs
  logic [VSQ_W-1:0] vx_sq, vy_sq;
  logic [RSQ_W-1:0] r_sq;
  logic [ASQ_W-1:0] a_sq;

  assign dot = DOT_W'(s2_pdx) + DOT_W'(s2_pdy) + DOT_W'(2 ** (RND_DOT - 1));

  // disc = (r^2 - |v|^2) * 2^16 + a^2, Q.48
  assign disc = {{(DISC_W-DIFF_W-16){s5_diff[DIFF_W-1]}}, s5_diff, 16'b0}
              + DISC_W'(a_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= req_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vx      <= {req.circle_center_x[COORD_W-1], req.circle_center_x}
                  - {req.ray_origin_x[COORD_W-1], req.ray_origin_x};
      s1_vy      <= {req.circle_center_y[COORD_W-1], req.circle_center_y}
                  - {req.ray_origin_y[COORD_W-1], req.ray_origin_y};
      s1_r       <= req.circle_radius;
      s1_pass.ox <= req.ray_origin_x;
      s1_pass.oy <= req.ray_origin_y;
      s1_pass.dx <= req.ray_dir_x;
      s1_pass.dy <= req.ray_dir_y;
      s1_pass.id <= req.body_id;

      s2_pdx  <= s1_vx * s1_pass.dx;
      s2_pdy  <= s1_vy * s1_pass.dy;
      s2_pass <= s1_pass;

      s3_a    <= dot[DOT_W-1:RND_DOT];
      s3_pass <= s2_pass;

      s4_v2   <= vx_sq + vy_sq;
      s4_r2   <= r_sq;
      s4_a    <= s3_a;
      s4_pass <= s3_pass;

      s5_diff   <= DIFF_W'(s4_r2) - DIFF_W'(s4_v2);
      s5_inside <= (s4_v2 < VSQ_W'(s4_r2));
      s5_a      <= s4_a;
      s5_pass   <= s4_pass;

      // a miss still runs down the chain; its root is ignored
      s6_rad            <= disc[RAD_W-1:0];
      s6_side.hit       <= !disc[DISC_W-1];
      s6_side.in_circle <= s5_inside;
      s6_side.a         <= s5_a;
      s6_side.pass      <= s5_pass;
    end
  end

  rci_square #(.N(V_W)) u_sq_vx (
    .clk (clk), .en (en), .x (s1_vx), .sq (vx_sq)
  );

  rci_square #(.N(V_W)) u_sq_vy (
    .clk (clk), .en (en), .x (s1_vy), .sq (vy_sq)
  );

  rci_square #(.N(COORD_W)) u_sq_r (
    .clk (clk), .en (en), .x ({1'b0, s1_r}), .sq (r_sq)
  );

  // a^2 lands in step with stage 5
  rci_square #(.N(A_W)) u_sq_a (
    .clk (clk), .en (en), .x (s3_a), .sq (a_sq)
  );

  // ---- square root chain: one root bit per cell ---------------------------
  logic              cv    [ROOT_W+1];
  logic [RAD_W-1:0]  crad  [ROOT_W+1];
  logic [REM_W-1:0]  crem  [ROOT_W+1];
  logic [ROOT_W-1:0] croot [ROOT_W+1];
  rci_side_t         cside [ROOT_W+1];

  assign cv[0]    = s6_valid;
  assign crad[0]  = s6_rad;
  assign crem[0]  = '0;
  assign croot[0] = '0;
  assign cside[0] = s6_side;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_root
    rci_root_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .src_valid (cv[g]),
      .src_rad   (crad[g]),
      .src_rem   (crem[g]),
      .src_root  (croot[g]),
      .src_side  (cside[g]),
      .valid     (cv[g+1]),
      .rad       (crad[g+1]),
      .rem       (crem[g+1]),
      .root      (croot[g+1]),
      .side      (cside[g+1])
    );
  end

  // ---- stage 7: t = a -/+ f, rounded to Q.16 ------------------------------
  logic                      s7_valid;
  logic signed [T16_W-1:0]   s7_t16;
  rci_side_t                 s7_side;
  logic        [T24_W-1:0]   t_a, t_f, t24, t24_rnd;

  assign t_a     = {{(T24_W-A_W){cside[ROOT_W].a[A_W-1]}}, cside[ROOT_W].a};
  assign t_f     = T24_W'(croot[ROOT_W]);
  assign t24     = cside[ROOT_W].in_circle ? (t_a + t_f) : (t_a - t_f);
  assign t24_rnd = t24 + T24_W'(2 ** (RND_T - 1));

  // ---- stage 8: d * t ----------------------------------------------------
  logic                      s8_valid;
  logic signed [MT_W-1:0]    s8_mx, s8_my;
  logic signed [T16_W-1:0]   s8_t16;
  rci_side_t                 s8_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= cv[ROOT_W];
      s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_t16  <= t24_rnd[T24_W-1:RND_T];
      s7_side <= cside[ROOT_W];

      s8_mx   <= s7_side.pass.dx * s7_t16;
      s8_my   <= s7_side.pass.dy * s7_t16;
      s8_t16  <= s7_t16;
      s8_side <= s7_side;
    end
  end

  // ---- result assembly ----------------------------------------------------
  logic [MT_W-1:0] mx_rnd, my_rnd;
  logic [PS_W-1:0] px_sum, py_sum;
  logic            t_pos, t_neg;
  rci_rsp_t        res;

  assign mx_rnd = s8_mx + MT_W'(2 ** (RND_P - 1));
  assign my_rnd = s8_my + MT_W'(2 ** (RND_P - 1));
  assign px_sum = {{(PS_W-COORD_W){s8_side.pass.ox[COORD_W-1]}}, s8_side.pass.ox}
                + {{(PS_W-PR_W){mx_rnd[MT_W-1]}}, mx_rnd[MT_W-1:RND_P]};
  assign py_sum = {{(PS_W-COORD_W){s8_side.pass.oy[COORD_W-1]}}, s8_side.pass.oy}
                + {{(PS_W-PR_W){my_rnd[MT_W-1]}}, my_rnd[MT_W-1:RND_P]};
  assign t_neg  = s8_t16[T16_W-1];
  assign t_pos  = !t_neg && (s8_t16 != '0);

  always_comb begin
    res = '0;
    if (s8_side.hit) begin
      res.hit         = 1'b1;
      res.hit_point_x = sat_coord(px_sum);
      res.hit_point_y = sat_coord(py_sum);
      res.distance    = sat_coord({{(PS_W-T16_W){s8_t16[T16_W-1]}}, s8_t16});
      res.hit_body    = s8_side.pass.id;
      // normal points from the hit back to the origin
      if (t_pos) begin
        res.normal_x = neg_dir(s8_side.pass.dx);
        res.normal_y = neg_dir(s8_side.pass.dy);
      end else if (t_neg) begin
        res.normal_x = s8_side.pass.dx;
        res.normal_y = s8_side.pass.dy;
      end
    end
  end

  rci_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .src_valid (s8_valid),
    .src       (res),
    .valid     (rsp_valid),
    .data      (rsp),
    .stall     (rsp_stall),
    .full      (full)
  );

  // ---- assertions ---------------------------------------------------------

  // the skid entry only fills behind a response already on the port
  a_skid_behind_rsp: assert property (@(posedge clk) disable iff (rst)
    full |-> rsp_valid)
    else $error("skid entry full without a response on the port");

  // a miss response carries nothing but zeros
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.hit |-> rsp.hit_point_x == '0 && rsp.hit_point_y == '0
      && rsp.normal_x == '0 && rsp.normal_y == '0 && rsp.distance == '0
      && rsp.hit_body == '0)
    else $error("miss response with nonzero fields");

  // while the skid entry is full, the root chain holds its tail
  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    full |=> $stable(cv[ROOT_W]) && $stable(croot[ROOT_W]))
    else $error("root chain moved while the pipeline was held");

endmodule
`default_nettype wire

/* tb/ray_circle_intersect_top_test.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ray_circle_intersect_top_test: self-checking bench for the ray/circle block
// Sends directed and random ray/circle requests with random idle gaps on the
// request side and random stalls on the response side. Each accepted request
// is run through an independent fixed-point model of the intersection. Every
// response is compared field by field, in order, against that prediction.
// ---------------------------------------------------------------------------
module ray_circle_intersect_top_test
  import rci_pkg::*;
();

  localparam int ONE          = 65536;         // 1.0 in Q16.16
  localparam int DIR_ONE      = 16384;         // 1.0 in Q2.14
  localparam int CMAX         = 2147483647;
  localparam int CMIN         = -CMAX - 1;
  localparam int RANDOM_REQS  = 550;
  localparam int PHASE_LEN    = 50;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_WAIT     = 11;

  // Scoreboard: predicts the response for each accepted request and checks
  // returned responses against the oldest prediction.
  class intersect_scoreboard;
    rci_rsp_t pending_hits[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function logic signed [COORD_W-1:0] clamp_coord(longint v);
      longint top;
      top = (longint'(1) <<< (COORD_W - 1)) - 1;
      if (v > top) return COORD_MAX;
      if (v < -top - 1) return COORD_MIN;
      return v[COORD_W-1:0];
    endfunction

    // negate a direction component; the most negative code saturates
    function logic signed [DIR_W-1:0] flip_dir(logic signed [DIR_W-1:0] d);
      return (d == DIR_MIN) ? DIR_MAX : -d;
    endfunction

    function rci_rsp_t intersect_ray_circle(rci_req_t q);
      longint              ox, oy, dx, dy, vx, vy, proj, root_l, t_fine, t_q16;
      logic signed [127:0] wvx, wvy, wr, wproj, vsq, rsq, disc;
      logic [127:0]        cand_sq;
      logic [63:0]         root, cand;
      logic                in_circle;
      rci_rsp_t            o;
      o  = '0;
      ox = q.ray_origin_x;
      oy = q.ray_origin_y;
      dx = q.ray_dir_x;
      dy = q.ray_dir_y;
      vx = longint'(q.circle_center_x) - ox;
      vy = longint'(q.circle_center_y) - oy;
      // projection v.d, Q.30 rounded to Q.24
      proj = (vx * dx + vy * dy + (longint'(1) <<< (RND_DOT - 1))) >>> RND_DOT;
      wvx   = vx;
      wvy   = vy;
      wr    = q.circle_radius;
      wproj = proj;
      vsq   = wvx * wvx + wvy * wvy;
      rsq   = wr * wr;
      in_circle = vsq < rsq;
      disc  = (rsq <<< 16) - ((vsq <<< 16) - wproj * wproj);
      if (disc[127]) return o;           // line misses the circle
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        cand    = root | (64'd1 << b);
        cand_sq = {64'd0, cand} * {64'd0, cand};
        if (cand_sq <= disc) root = cand;
      end
      root_l = longint'(root);
      t_fine = in_circle ? proj + root_l : proj - root_l;
      t_q16  = (t_fine + (longint'(1) <<< (RND_T - 1))) >>> RND_T;
      o.hit         = 1'b1;
      o.distance    = clamp_coord(t_q16);
      o.hit_point_x = clamp_coord(ox + ((dx * t_q16 + (longint'(1) <<< (RND_P - 1))) >>> RND_P));
      o.hit_point_y = clamp_coord(oy + ((dy * t_q16 + (longint'(1) <<< (RND_P - 1))) >>> RND_P));
      if (t_q16 > 0) begin
        o.normal_x = flip_dir(q.ray_dir_x);
        o.normal_y = flip_dir(q.ray_dir_y);
      end else if (t_q16 < 0) begin
        o.normal_x = q.ray_dir_x;
        o.normal_y = q.ray_dir_y;
      end
      o.hit_body = q.body_id;
      return o;
    endfunction

    function void note_ray(rci_req_t q);
      pending_hits.push_back(intersect_ray_circle(q));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_hit(rci_rsp_t got);
      rci_rsp_t want;
      if (pending_hits.size() == 0) begin
        $display("%0t: response with no request pending, expected none actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = pending_hits.pop_front();
      compare_field("hit", want.hit, got.hit);
      compare_field("hit_point_x", want.hit_point_x, got.hit_point_x);
      compare_field("hit_point_y", want.hit_point_y, got.hit_point_y);
      compare_field("normal_x", want.normal_x, got.normal_x);
      compare_field("normal_y", want.normal_y, got.normal_y);
      compare_field("distance", want.distance, got.distance);
      compare_field("hit_body", want.hit_body, got.hit_body);
    endfunction

    function int outstanding();
      return pending_hits.size();
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  rci_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b1;
  rci_rsp_t rsp;

  // idle mode per phase: a set bit means that side runs without gaps
  logic send_burst = 1'b0;
  logic rsp_burst  = 1'b0;

  intersect_scoreboard sb = new();

  ray_circle_intersect_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop; a correct run ends far sooner, even with every gap and stall
  // at its longest
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // signed random value of k bits
  function automatic int srand_bits(int k);
    int v;
    v = $urandom;
    return v >>> (32 - k);
  endfunction

  function automatic int next_gap();
    return send_burst ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic rci_req_t mk_req(int ox,
                                      int oy,
                                      int dx,
                                      int dy,
                                      int cx,
                                      int cy,
                                      int r,
                                      logic [ID_W-1:0] id);
    rci_req_t q;
    q.ray_origin_x    = COORD_W'(ox);
    q.ray_origin_y    = COORD_W'(oy);
    q.ray_dir_x       = DIR_W'(dx);
    q.ray_dir_y       = DIR_W'(dy);
    q.circle_center_x = COORD_W'(cx);
    q.circle_center_y = COORD_W'(cy);
    q.circle_radius   = (COORD_W-1)'(r);
    q.body_id         = id;
    return q;
  endfunction

  function automatic int corner_coord();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return -1;
      2:       return 1;
      3:       return CMAX;
      4:       return CMIN;
      default: return $urandom;
    endcase
  endfunction

  function automatic int corner_dir();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return DIR_ONE;
      2:       return -DIR_ONE;
      3:       return 32767;
      4:       return -32768;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Random request. Most are geometric: a unit direction and a circle placed
  // near the origin or along the ray at a random scale, so hits and misses
  // both show up. The rest are raw bit patterns and corner values.
  function automatic rci_req_t rand_ray();
    rci_req_t q;
    int       mag, oth, k, ox, oy, dx, dy, cx, cy, r;
    longint   s;
    q = '0;
    case ($urandom_range(0, 9))
      0, 1: begin
        q = mk_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, ID_W'($urandom));
      end
      2: begin
        q = mk_req(corner_coord(), corner_coord(), corner_dir(), corner_dir(),
                   corner_coord(), corner_coord(),
                   ($urandom_range(0, 1) != 0) ? CMAX : int'($urandom),
                   ID_W'($urandom));
      end
      default: begin
        k  = $urandom_range(6, 30);
        ox = srand_bits($urandom_range(8, 32));
        oy = srand_bits($urandom_range(8, 32));
        if ($urandom_range(0, 7) == 0) begin
          dx = srand_bits(16);        // not unit length, used as given
          dy = srand_bits(16);
        end else begin
          mag = $urandom_range(0, DIR_ONE);
          oth = $rtoi($sqrt(real'(DIR_ONE * DIR_ONE - mag * mag)) + 0.5);
          if ($urandom_range(0, 1) != 0) mag = -mag;
          if ($urandom_range(0, 1) != 0) oth = -oth;
          if ($urandom_range(0, 1) != 0) begin
            dx = mag;
            dy = oth;
          end else begin
            dx = oth;
            dy = mag;
          end
        end
        if ($urandom_range(0, 1) != 0) begin
          // aimed along the ray, ahead or behind
          s  = srand_bits(k + 1);
          cx = ox + int'((longint'(dx) * s) >>> 14) + srand_bits(k - 2);
          cy = oy + int'((longint'(dy) * s) >>> 14) + srand_bits(k - 2);
        end else begin
          cx = ox + srand_bits(k);
          cy = oy + srand_bits(k);
        end
        r = $urandom >> (32 - k);
        q = mk_req(ox, oy, dx, dy, cx, cy, r, ID_W'($urandom));
      end
    endcase
    return q;
  endfunction

  // One request: idle for the drawn gap, then hold valid until accepted.
  task automatic send_req(rci_req_t q);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= q;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_ray(q);
  endtask

  // Response side: stall for a drawn number of cycles, then take the next
  // response and check it.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = rsp_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
      sb.check_hit(rsp);
    end
  end

  initial begin
    logic [1:0] mode;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed requests
    send_req(mk_req(0, 0, DIR_ONE, 0, 10 * ONE, 0, 2 * ONE, 16'h0001));     // hit ahead
    send_req(mk_req(0, 0, DIR_ONE, 0, 10 * ONE, 5 * ONE, 2 * ONE, 16'h0002)); // miss
    send_req(mk_req(0, 0, DIR_ONE, 0, 10 * ONE, 2 * ONE, 2 * ONE, 16'h0003)); // tangent
    send_req(mk_req(3 * ONE, -ONE, 0, DIR_ONE, 3 * ONE, -ONE, 4 * ONE, 16'h0004)); // inside
    send_req(mk_req(0, 0, DIR_ONE, 0, -10 * ONE, 0, 2 * ONE, 16'h0005));    // behind
    send_req(mk_req(0, 0, DIR_ONE, 0, 2 * ONE, 0, 2 * ONE, 16'h0006));      // zero distance
    send_req(mk_req(ONE, ONE, 0, 0, ONE, ONE + ONE / 2, ONE, 16'h0007));    // zero dir, inside
    send_req(mk_req(0, 0, 0, 0, 3 * ONE, 0, ONE, 16'h0008));                // zero dir, miss
    send_req(mk_req(0, 0, -32768, 0, -10 * ONE, 0, 2 * ONE, 16'h0009));     // negate saturates
    send_req(mk_req(0, 0, 0, -32768, 0, -10 * ONE, ONE, 16'h000A));
    send_req(mk_req(0, 0, 32767, 32767, 5 * ONE, 5 * ONE, ONE, 16'h000B));  // non-unit dir
    send_req(mk_req(-ONE, -ONE, 11585, 11585, 4 * ONE, 4 * ONE, ONE, 16'h000C));
    send_req(mk_req(CMAX, CMAX, DIR_ONE, DIR_ONE, CMIN, CMIN, CMAX, 16'hFFFF));
    send_req(mk_req(CMIN, CMIN, -DIR_ONE, -DIR_ONE, CMAX, CMAX, CMAX, 16'h0000));
    send_req(mk_req(CMIN, CMAX, DIR_ONE, -DIR_ONE, CMIN, CMAX, CMAX,
                    16'h8000));                                             // point clamps
    send_req(mk_req(CMAX, 0, DIR_ONE, 0, CMAX, 0, CMAX, 16'h7FFF));
    send_req(mk_req(-1, -1, -1, -1, -1, -1, 0, 16'hFFFF));                  // zero radius
    send_req(mk_req(0, 0, DIR_ONE, 0, 7 * ONE, 0, 0, 16'h5555));            // point circle
    send_req(mk_req(0, 0, -DIR_ONE, DIR_ONE, 0, 0, CMAX, 16'hAAAA));
    send_req(mk_req(ONE, 2 * ONE, -DIR_ONE, 0, -20 * ONE, 2 * ONE, 3 * ONE, 16'h1234));
    send_req(mk_req(12345, -6789, 9000, -13690, 40 * ONE, -60 * ONE, 30 * ONE, 16'h4321));
    send_req(mk_req(CMIN, CMIN, 32767, 32767, CMAX, CMAX, 1, 16'h00FF));

    // random requests, idle mode changes every phase
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % PHASE_LEN == 0) begin
        mode       = 2'($urandom_range(0, 3));
        send_burst = mode[0];
        rsp_burst  = mode[1];
      end
      send_req(rand_ray());
    end
    req_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
